FILE: rtl/assert_macros.svh
// Assertion macros used by the checker of the section filter.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SFM_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("section filter assertion failed");

// Next-cycle implication, ignored while reset is high.
`define SFM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("section filter assertion failed");

// Next-cycle implication that is also checked across reset.
`define SFM_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("section filter assertion failed");

`endif

FILE: rtl/sfm_pkg.sv
// Shared types and constants of the section filter.
// Used by sfm_entry, section_filter_match and the checker; depends on nothing.
package sfm_pkg;

   localparam int ENTRIES_DEF       = 16;
   localparam int PATTERN_BYTES_DEF = 16;
   localparam int SKIP_GAP          = 2;

   typedef enum logic [1:0] {
      OP_PATTERN = 2'd0,
      OP_HEADER  = 2'd1,
      OP_PACKET  = 2'd2
   } op_type;

   // Pattern byte write into one entry's store.
   typedef struct packed {
      logic       en;
      logic [7:0] value;
      logic [7:0] mask;
   } wr_type;

   // Compare request for the packet byte held in the input stage.
   typedef struct packed {
      logic       plain_en;
      logic       skip_en;
      logic [7:0] data;
   } cmp_type;

endpackage

FILE: rtl/sfm_ram.sv
// Generic RAM: one write port and two registered read ports.
// Stand-alone; no package needed.
module sfm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/sfm_entry.sv
// One filter entry: its pattern/mask store and the plain and skip comparators.
// Depends on sfm_pkg and sfm_ram.
module sfm_entry #(
   parameter int PATTERN_BYTES = sfm_pkg::PATTERN_BYTES_DEF,
   localparam int PW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1
) (
   input  logic            clock,
   input  sfm_pkg::wr_type wr,
   input  logic [PW-1:0]   wr_addr,
   input  logic            rd_en,
   input  logic [PW-1:0]   rd_addr_plain,
   input  logic [PW-1:0]   rd_addr_skip,
   input  sfm_pkg::cmp_type cmp,
   output logic            plain_miss,
   output logic            skip_miss
);
   import sfm_pkg::*;

   // Each word holds the pattern byte above the mask byte.
   logic [15:0] plain_word;
   logic [15:0] skip_word;

   sfm_ram #(
      .WIDTH(16),
      .DEPTH(PATTERN_BYTES)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr.en),
      .wr_addr   (wr_addr),
      .wr_data   ({wr.value, wr.mask}),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_plain),
      .rd_addr_b (rd_addr_skip),
      .rd_data_a (plain_word),
      .rd_data_b (skip_word)
   );

   assign plain_miss = cmp.plain_en &&
      ((plain_word[15:8] & plain_word[7:0]) != (cmp.data & plain_word[7:0]));
   assign skip_miss = cmp.skip_en &&
      ((skip_word[15:8] & skip_word[7:0]) != (cmp.data & skip_word[7:0]));

endmodule

FILE: rtl/section_filter_match.sv
// Top level of the section filter: handshakes, entry headers, match state, result.
// Depends on sfm_pkg, sfm_entry and sfm_ram.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | op, entry, position, pattern, header, byte
//  rsp     | out       | rsp_valid / rsp_ready  | accept, one per packet at its last byte
//  csr     | in        | csr_valid / csr_ready  | bypass
//
// One transaction per cycle on req while req_ready is high; the result of a last byte passes
// the input stage (entry store read), then the compare and reduction into the rsp register.
// The store read is issued as the byte is taken, so the byte count sets the read address.
// Reset is synchronous; it clears headers and bypass and sets the match bits, not the stores.
// req_ready drops only during reset or while a result waits in rsp and a further last byte is held.
module section_filter_match #(
   parameter int ENTRIES       = sfm_pkg::ENTRIES_DEF,
   parameter int PATTERN_BYTES = sfm_pkg::PATTERN_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [3:0] req_entry,
   input  logic [3:0] req_position,
   input  logic [7:0] req_pattern_value,
   input  logic [7:0] req_pattern_mask,
   input  logic       req_entry_enabled,
   input  logic [1:0] req_entry_type,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic [1:0] req_packet_type,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accept,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_bypass
);
   import sfm_pkg::*;

   localparam int PW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int KW = $clog2(PATTERN_BYTES + SKIP_GAP + 1);
   localparam logic [KW-1:0] K_CAP = KW'(PATTERN_BYTES + SKIP_GAP);
   localparam logic [KW-1:0] K_PB  = KW'(PATTERN_BYTES);
   localparam logic [KW-1:0] K_GAP = KW'(SKIP_GAP);

   logic                bypass_ff;
   logic [ENTRIES-1:0]  enable_ff;
   logic [1:0]          kind_ff [ENTRIES];
   logic [ENTRIES-1:0]  plain_ok_ff, plain_ok_in;
   logic [ENTRIES-1:0]  skip_ok_ff, skip_ok_in;
   logic [KW-1:0]       pos_ff, pos_in;

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic                s1_last_ff;
   logic [1:0]          s1_ptype_ff;
   logic [KW-1:0]       s1_pos_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_accept_ff, rsp_accept_in;

   logic                req_fire, pkt_fire, pat_we, hdr_we, advance;
   logic [KW-1:0]       skip_k, s1_skip_k;
   logic [PW-1:0]       rd_addr_plain, rd_addr_skip, wr_addr;
   logic [ENTRIES-1:0]  plain_miss, skip_miss, plain_next, skip_next, hit;
   wr_type              wr_base;
   cmp_type             cmp;

   assign req_fire = req_valid && req_ready;
   assign pkt_fire = req_fire && (req_op == OP_PACKET);
   assign pat_we   = req_fire && (req_op == OP_PATTERN) &&
                     (32'(req_entry) < ENTRIES) && (32'(req_position) < PATTERN_BYTES);
   assign hdr_we   = req_fire && (req_op == OP_HEADER) && (32'(req_entry) < ENTRIES);

   // A last byte may leave the input stage only if the result slot frees up.
   assign advance   = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!s1_valid_ff || advance);
   assign csr_ready = !reset;

   // Read addresses for the byte being taken, which sits at position pos_ff.
   assign skip_k        = pos_ff - K_GAP;
   assign rd_addr_plain = (pos_ff < K_PB) ? PW'(pos_ff) : '0;
   assign rd_addr_skip  = ((pos_ff > K_GAP) && (skip_k < K_PB)) ? PW'(skip_k) : '0;
   assign wr_addr       = PW'(req_position);

   assign wr_base.en    = 1'b0;
   assign wr_base.value = req_pattern_value;
   assign wr_base.mask  = req_pattern_mask;

   assign s1_skip_k     = s1_pos_ff - K_GAP;
   assign cmp.plain_en  = s1_pos_ff < K_PB;
   assign cmp.skip_en   = (s1_pos_ff == '0) || ((s1_pos_ff > K_GAP) && (s1_skip_k < K_PB));
   assign cmp.data      = s1_byte_ff;

   for (genvar e = 0; e < ENTRIES; e++) begin : g_entry
      wr_type wr_e;

      always_comb begin
         wr_e    = wr_base;
         wr_e.en = pat_we && (32'(req_entry) == e);
      end

      sfm_entry #(
         .PATTERN_BYTES(PATTERN_BYTES)
      ) u_entry (
         .clock         (clock),
         .wr            (wr_e),
         .wr_addr       (wr_addr),
         .rd_en         (pkt_fire),
         .rd_addr_plain (rd_addr_plain),
         .rd_addr_skip  (rd_addr_skip),
         .cmp           (cmp),
         .plain_miss    (plain_miss[e]),
         .skip_miss     (skip_miss[e])
      );

      assign hit[e] = enable_ff[e] && (kind_ff[e] == s1_ptype_ff) &&
                      (plain_next[e] || skip_next[e]);
   end

   assign plain_next = plain_ok_ff & ~plain_miss;
   assign skip_next  = skip_ok_ff & ~skip_miss;

   always_comb begin
      plain_ok_in   = plain_ok_ff;
      skip_ok_in    = skip_ok_ff;
      rsp_accept_in = rsp_accept_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         if (s1_last_ff) begin
            plain_ok_in   = '1;
            skip_ok_in    = '1;
            rsp_valid_in  = 1'b1;
            rsp_accept_in = bypass_ff || (|hit);
         end else begin
            plain_ok_in = plain_next;
            skip_ok_in  = skip_next;
         end
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (pkt_fire) begin
         if (req_last) begin
            pos_in = '0;
         end else if (pos_ff < K_CAP) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign s1_valid_in = pkt_fire || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff    <= 1'b0;
         enable_ff    <= '0;
         plain_ok_ff  <= '1;
         skip_ok_ff   <= '1;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < ENTRIES; e++) begin
            kind_ff[e] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            bypass_ff <= csr_bypass;
         end
         for (int e = 0; e < ENTRIES; e++) begin
            if (hdr_we && (32'(req_entry) == e)) begin
               enable_ff[e] <= req_entry_enabled;
               kind_ff[e]   <= req_entry_type;
            end
         end
         plain_ok_ff  <= plain_ok_in;
         skip_ok_ff   <= skip_ok_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_fire) begin
         s1_byte_ff  <= req_data_byte;
         s1_last_ff  <= req_last;
         s1_ptype_ff <= req_packet_type;
         s1_pos_ff   <= pos_ff;
      end
      rsp_accept_ff <= rsp_accept_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_accept = rsp_accept_ff;

endmodule

FILE: rtl/sfm_check.sv
// Port-level checker of the section filter, bound to section_filter_match.
// Depends on sfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfm_check (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_op,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accept
);
   import sfm_pkg::*;

   logic last_taken;

   assign last_taken = req_valid && req_ready && (req_op == OP_PACKET) && req_last;

   // Reset empties the result register.
   `SFM_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // A fresh result follows the last byte of a packet that was taken through the input stage.
   `SFM_ASSERT_IMPLY(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(last_taken, 2))

   // The input side stalls only behind a result that is not being taken.
   `SFM_ASSERT_IMPLY(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // A result that is not taken holds its value.
   `SFM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_accept))

endmodule

bind section_filter_match sfm_check u_sfm_check (.*);
